/* rtl/trimming_three_class_queue_core_macros.svh */
// Assertion macros shared by the trimming queue RTL.
`ifndef TRIMMING_THREE_CLASS_QUEUE_CORE_MACROS_SVH
`define TRIMMING_THREE_CLASS_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TTQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TTQ_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTQ_ASSERT(label, clk, rst_n, prop, msg)
`define TTQ_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* rtl/ttq_pkg.sv */
// Package with types, codes and constants of the trimming queue.
package ttq_pkg;
  localparam int unsigned DefRingDepth = 64;
  localparam int unsigned DefTagBits   = 16;

  localparam logic [2:0] ActMid    = 3'd0;
  localparam logic [2:0] ActHigh   = 3'd1;
  localparam logic [2:0] ActLow    = 3'd2;
  localparam logic [2:0] ActBounce = 3'd3;
  localparam logic [2:0] ActDrop   = 3'd4;
  localparam logic [2:0] ActDepart = 3'd5;
  localparam logic [2:0] ActNone   = 3'd6;

  localparam logic [2:0] CfgMaxBytes = 3'd0;
  localparam logic [2:0] CfgWHigh    = 3'd1;
  localparam logic [2:0] CfgWMid     = 3'd2;
  localparam logic [2:0] CfgWLow     = 3'd3;
  localparam logic [2:0] CfgHdr      = 3'd4;

  localparam logic [1:0] SrvNone = 2'd0;
  localparam logic [1:0] SrvHigh = 2'd1;
  localparam logic [1:0] SrvMid  = 2'd2;
  localparam logic [1:0] SrvLow  = 2'd3;

  typedef struct packed {
    logic                  command;
    logic [DefTagBits-1:0] packet_tag;
    logic [2:0]            packet_kind;
    logic [13:0]           size_bytes;
    logic                  hdr_only;
    logic                  has_return_path;
    logic                  already_bounced;
    logic                  random_bit;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_tag;
    logic [2:0]  action;
    logic        was_trimmed;
    logic [13:0] out_size;
    logic [2:0]  out_kind;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_BOOT, ST_SERVE, ST_EMIT
  } eng_state_t;
endpackage

/* rtl/trimming_three_class_queue_core.sv */
// Results are registered: an accepted item passes the input queue, the item register
// and the DECIDE and BOOT states before its results are offered. A new item is taken
// only once the last one's results are all taken and any service choice is made.
// A two-entry input queue absorbs items while the engine works.
// Reset (rst_n, synchronous, active low) empties all rings and restores
// the register defaults; ring contents need no clearing.
module trimming_three_class_queue_core import ttq_pkg::*; #(
  parameter int unsigned RING_DEPTH = DefRingDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  logic [23:0] max_bytes_r;
  logic [15:0] w_high_r, w_mid_r, w_low_r;
  logic [7:0]  hdr_r;
  logic        q_valid, q_ready;
  in_item_t    q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= 24'd131072; w_high_r <= 16'd64; w_mid_r <= 16'd4500;
      w_low_r <= 16'd1500; hdr_r <= 8'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgMaxBytes: max_bytes_r <= cfg_wdata;
        CfgWHigh:    w_high_r <= cfg_wdata[15:0];
        CfgWMid:     w_mid_r <= cfg_wdata[15:0];
        CfgWLow:     w_low_r <= cfg_wdata[15:0];
        CfgHdr:      hdr_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  ttq_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data));

  ttq_engine #(.RING_DEPTH(RING_DEPTH)) u_engine (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_data(q_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .max_bytes(max_bytes_r), .w_high(w_high_r),
    .w_mid(w_mid_r), .w_low(w_low_r), .hdr_bytes(hdr_r));
endmodule

/* rtl/ttq_ram.sv */
// Generic single-port-write, registered-read RAM.
module ttq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/ttq_front.sv */
// Input stage: accept items and hold them in a two-entry queue.
module ttq_front import ttq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output in_item_t q_data
);
  `include "trimming_three_class_queue_core_macros.svh"
  in_item_t  ent_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic      push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = ent_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= in_data;
  end

  `TTQ_ASSERT(a_fq_bound, clk, rst_n, cnt_r <= 2'd2, "front queue overflow")
  `TTQ_ASSERT(a_fq_ptrs, clk, rst_n, (cnt_r == 2'd1) |-> (wp_r != rp_r), "front pointers")
  `TTQ_ASSERT(a_fq_push, clk, rst_n, (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1), "push")
endmodule

/* rtl/ttq_engine.sv */
// Back end: ring memories, admission, trimming and weighted service.
module ttq_engine import ttq_pkg::*; #(
  parameter int unsigned RING_DEPTH = DefRingDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  in_item_t    q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic [23:0] max_bytes,
  input  logic [15:0] w_high,
  input  logic [15:0] w_mid,
  input  logic [15:0] w_low,
  input  logic [7:0]  hdr_bytes
);
  `include "trimming_three_class_queue_core_macros.svh"
  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned DW = DefTagBits + 14 + 3 + 2;
  localparam logic [CW-1:0] FullCnt = CW'(RING_DEPTH);

  typedef struct packed {
    logic [DefTagBits-1:0] tag;
    logic [13:0]           size;
    logic [2:0]            kind;
    logic                  ret;
    logic                  bnc;
  } desc_t;

  eng_state_t st_r, st_nxt;
  in_item_t   it_r;
  logic [AW-1:0] rdp_r [3];
  logic [CW-1:0] cnt_r [3];
  logic [24:0]   qb_r [3];
  logic [17:0]   credit_r;
  logic [1:0]    srv_r;
  out_item_t     ob_r [2];
  logic [1:0]    on_r;
  logic          op_r;
  logic          pend_r;

  logic [2:0]    we;
  logic [AW-1:0] waddr [3];
  logic [AW-1:0] raddr [3];
  desc_t         wd [3];
  logic [DW-1:0] rd [3];
  desc_t         rdd [3];

  for (genvar g = 0; g < 3; g++) begin : g_ring
    ttq_ram #(.WIDTH(DW), .DEPTH(RING_DEPTH)) u_ram (
      .clk(clk), .we(we[g]), .waddr(waddr[g]), .wdata(wd[g]),
      .raddr(raddr[g]), .rdata(rd[g]));
    assign rdd[g] = desc_t'(rd[g]);
  end

  function automatic logic fits(logic [CW-1:0] c, logic [24:0] b, logic [13:0] s,
                                logic [23:0] mx);
    logic [25:0] t;
    t = {1'b0, b} + 26'(s);
    return (c != FullCnt) && (t <= 26'(mx));
  endfunction

  // Ring index advance; the sum stays below twice the depth, so one subtract wraps it.
  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] r, logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(r) + SW'(off);
    if (s >= SW'(RING_DEPTH)) s = s - SW'(RING_DEPTH);
    return s[AW-1:0];
  endfunction

  logic [AW-1:0] mid_new;
  assign mid_new = ring_add(rdp_r[1], (cnt_r[1] == '0) ? '0 : cnt_r[1] - CW'(1));

  desc_t din;
  always_comb begin
    din.tag  = it_r.packet_tag;
    din.size = it_r.size_bytes;
    din.kind = it_r.packet_kind;
    din.ret  = it_r.has_return_path;
    din.bnc  = it_r.already_bounced;
  end

  logic out_busy;
  assign out_busy = (on_r != 2'd0);
  assign q_ready  = (st_r == ST_IDLE) && !out_busy && !pend_r;
  assign out_valid = out_busy;
  assign out_data  = ob_r[op_r];

  always_comb begin
    unique case (st_r)
      ST_IDLE:   st_nxt = pend_r ? ST_SERVE : ((q_valid && q_ready) ? ST_DECIDE : ST_IDLE);
      ST_DECIDE: st_nxt = ST_BOOT;
      ST_BOOT:   st_nxt = ST_EMIT;
      ST_SERVE:  st_nxt = ST_EMIT;
      ST_EMIT:   st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // Read addresses: newest of mid for an arrival, oldest of each ring otherwise.
  always_comb begin
    for (int i = 0; i < 3; i++) raddr[i] = rdp_r[i];
    if (st_r == ST_DECIDE && !it_r.command) raddr[1] = mid_new;
  end

  function automatic out_item_t mk(logic [DefTagBits-1:0] t, logic [2:0] a, logic tr,
                                   logic [13:0] s, logic [2:0] k);
    out_item_t o;
    o.out_tag = 16'(t); o.action = a; o.was_trimmed = tr;
    o.out_size = s; o.out_kind = k; o.last = 1'b0;
    return o;
  endfunction

  function automatic logic [AW-1:0] tail(logic [AW-1:0] r, logic [CW-1:0] c);
    return ring_add(r, c);
  endfunction

  logic [17:0] wsum, whm;
  assign wsum = 18'(w_high) + 18'(w_mid) + 18'(w_low);
  assign whm  = 18'(w_high) + 18'(w_mid);

  always_ff @(posedge clk) begin
    logic [17:0] cr;
    desc_t h;
    logic [2:0] a;
    out_item_t r0, r1;
    logic [1:0] n;
    logic needsrv;
    if (!rst_n) begin
      st_r <= ST_IDLE; on_r <= 2'd0; op_r <= 1'b0; pend_r <= 1'b0;
      credit_r <= 18'd0; srv_r <= SrvNone;
      for (int i = 0; i < 3; i++) begin
        rdp_r[i] <= '0; cnt_r[i] <= '0; qb_r[i] <= '0;
      end
      we <= 3'b0;
    end else begin
      st_r <= st_nxt;
      we <= 3'b0;
      if (out_valid && out_ready) begin
        op_r <= (on_r == 2'd1) ? 1'b0 : ~op_r;
        on_r <= on_r - 2'd1;
      end
      if (st_r == ST_IDLE && q_valid && q_ready) it_r <= q_data;
      if (st_r == ST_BOOT) begin
        n = 2'd1; r1 = '0; needsrv = (srv_r == SrvNone);
        h = din;
        r0 = mk(din.tag, ActDrop, 1'b0, din.size, din.kind);
        if (it_r.command) begin
          needsrv = 1'b1;
          if (srv_r == SrvNone || cnt_r[srv_r - 2'd1] == '0) begin
            r0 = mk('0, ActNone, 1'b0, 14'd0, 3'd0);
          end else begin
            r0 = mk(rdd[srv_r - 2'd1].tag, ActDepart, 1'b0,
                    rdd[srv_r - 2'd1].size, rdd[srv_r - 2'd1].kind);
            rdp_r[srv_r - 2'd1] <= ring_add(rdp_r[srv_r - 2'd1], CW'(1));
            cnt_r[srv_r - 2'd1] <= cnt_r[srv_r - 2'd1] - CW'(1);
            qb_r[srv_r - 2'd1] <= qb_r[srv_r - 2'd1] - 25'(rdd[srv_r - 2'd1].size);
          end
          srv_r <= SrvNone;
        end else if (din.kind > 3'd5) begin
          r0 = mk(din.tag, ActDrop, 1'b0, din.size, din.kind);
        end else if (din.kind >= 3'd4) begin
          if (fits(cnt_r[2], qb_r[2], din.size, max_bytes)) begin
            r0 = mk(din.tag, ActLow, 1'b0, din.size, din.kind);
            we[2] <= 1'b1; waddr[2] <= tail(rdp_r[2], cnt_r[2]); wd[2] <= din;
            cnt_r[2] <= cnt_r[2] + CW'(1); qb_r[2] <= qb_r[2] + 25'(din.size);
          end
        end else begin
          logic trim, boot;
          trim = 1'b0; boot = 1'b0;
          if (!it_r.hdr_only) begin
            if (fits(cnt_r[1], qb_r[1], din.size, max_bytes)) begin
              r0 = mk(din.tag, ActMid, 1'b0, din.size, din.kind);
              we[1] <= 1'b1; waddr[1] <= tail(rdp_r[1], cnt_r[1]); wd[1] <= din;
              cnt_r[1] <= cnt_r[1] + CW'(1); qb_r[1] <= qb_r[1] + 25'(din.size);
            end else if (it_r.random_bit && cnt_r[1] != '0 && rdd[1].size >= din.size) begin
              boot = 1'b1; trim = 1'b1; h = rdd[1];
              // Replace newest mid entry in place with the arrival.
              we[1] <= 1'b1; waddr[1] <= mid_new; wd[1] <= din;
              qb_r[1] <= qb_r[1] - 25'(rdd[1].size) + 25'(din.size);
              r1 = mk(din.tag, ActMid, 1'b0, din.size, din.kind);
              n = 2'd2;
            end else begin
              trim = 1'b1;
            end
          end
          if (it_r.hdr_only || trim) begin
            if (trim) h.size = 14'(hdr_bytes);
            if (fits(cnt_r[0], qb_r[0], h.size, max_bytes)) begin
              a = ActHigh;
              we[0] <= 1'b1; waddr[0] <= tail(rdp_r[0], cnt_r[0]); wd[0] <= h;
              cnt_r[0] <= cnt_r[0] + CW'(1); qb_r[0] <= qb_r[0] + 25'(h.size);
            end else if (h.ret && !h.bnc) a = ActBounce;
            else a = ActDrop;
            r0 = mk(h.tag, a, trim, h.size, h.kind);
          end
        end
        if (n == 2'd2) begin r1.last = 1'b1; end else r0.last = 1'b1;
        ob_r[0] <= r0; ob_r[1] <= r1; on_r <= n; op_r <= 1'b0;
        pend_r <= needsrv;
      end
      // Pick the next ring to serve once counts and heads have settled.
      if (st_r == ST_SERVE) begin
        pend_r <= 1'b0;
        if (cnt_r[0] != '0 && cnt_r[1] != '0 && cnt_r[2] != '0) begin
          cr = (credit_r >= wsum) ? 18'd0 : credit_r;
          if (cr < 18'(w_high)) begin
            srv_r <= SrvHigh; credit_r <= cr + 18'(hdr_bytes);
          end else if (cr < whm) begin
            srv_r <= SrvMid; credit_r <= cr + 18'(rdd[1].size);
          end else begin
            srv_r <= SrvLow; credit_r <= cr + 18'(rdd[2].size);
          end
        end else if (cnt_r[0] != '0) srv_r <= SrvHigh;
        else if (cnt_r[1] != '0) srv_r <= SrvMid;
        else if (cnt_r[2] != '0) srv_r <= SrvLow;
        else srv_r <= SrvNone;
      end
    end
  end

  `TTQ_ASSERT(a_cnt_hi, clk, rst_n, cnt_r[0] <= FullCnt, "high count")
  `TTQ_ASSERT(a_cnt_mid, clk, rst_n, cnt_r[1] <= FullCnt, "mid count")
  `TTQ_ASSERT(a_out_last, clk, rst_n,
    (out_valid && on_r == 2'd1) |-> out_data.last, "last flag missing")
  `TTQ_ASSERT(a_busy, clk, rst_n, q_ready |-> !out_valid, "accepted while results pend")
endmodule
